// File: hdl/lpst_pkg.sv
// Shared constants and types for the linear probe slot table.
package lpst_pkg;

	// Slot count; a power of two, so the home slot is the low bits of the value.
	localparam int TABLE_SLOTS = 1024;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
	localparam int VALUE_W     = 63;
	localparam int READ_W      = 64;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [READ_W-1:0]  read_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

endpackage

// File: hdl/lpst_ram.sv
// Generic simple dual-port RAM with registered read.
module lpst_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/linear_probe_slot_table_top.sv
// Linear probe slot table: occupancy bitmap probed one slot per cycle.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, op, value    | into block
//  out     | out_valid, out_stall,            | out of block
//          | read_value, insert_dropped       |
//
// Query: the home slot is read through the registered RAM port, then the result is loaded.
// Insert: the used slots from home are passed until the free one is found; one probe per
// cycle through the occupancy RAM read port. Insert into a full table: no probe, insert_dropped is set.
// After reset a clearing pass writes all TABLE_SLOTS (1024) occupancy RAM entries;
// in_stall stays high during it. One item at a time; the output register
// holds a result under out_stall while the next transfer is taken in.
module linear_probe_slot_table_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   op,
	input  lpst_pkg::value_t       value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lpst_pkg::read_t        read_value,
	output logic                   insert_dropped
);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_QUERY,
		ST_PROBE,
		ST_DROP
	} state_t;

	state_t            state_q;
	lpst_pkg::slot_t   pos_q;
	lpst_pkg::slot_t   nxt_pos;
	lpst_pkg::slot_t   raddr;
	lpst_pkg::count_t  count_q;
	lpst_pkg::value_t  val_q;
	lpst_pkg::value_t  val_rd;
	lpst_pkg::read_t   read_value_q;
	logic              dropped_q;
	logic              out_valid_q;
	logic              used_rd;
	logic              used_we;
	logic              used_wdata;
	logic              val_we;
	logic              out_free;
	logic              res_ld;

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign insert_dropped = dropped_q;
	assign out_free       = !out_valid_q || !out_stall;

	assign nxt_pos = (pos_q == lpst_pkg::slot_t'(lpst_pkg::TABLE_SLOTS - 1)) ?
		'0 : pos_q + 1'b1;

	always_comb begin
		case (state_q)
			ST_IDLE:  raddr = value[lpst_pkg::SLOT_W-1:0];
			// keep the read on the current slot while waiting for the output
			ST_PROBE: raddr = used_rd ? nxt_pos : pos_q;
			default:  raddr = pos_q;
		endcase
		val_we     = (state_q == ST_PROBE) && !used_rd && out_free;
		used_we    = (state_q == ST_CLR) || val_we;
		used_wdata = (state_q != ST_CLR);
		res_ld     = val_we ||
			(out_free && ((state_q == ST_QUERY) || (state_q == ST_DROP)));
	end

	lpst_ram #(
		.WIDTH (1),
		.DEPTH (lpst_pkg::TABLE_SLOTS)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (pos_q),
		.wdata (used_wdata),
		.raddr (raddr),
		.rdata (used_rd)
	);

	lpst_ram #(
		.WIDTH (lpst_pkg::VALUE_W),
		.DEPTH (lpst_pkg::TABLE_SLOTS)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (pos_q),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			pos_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					pos_q <= nxt_pos;
					if (pos_q == lpst_pkg::slot_t'(lpst_pkg::TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						val_q <= value;
						pos_q <= value[lpst_pkg::SLOT_W-1:0];
						if (op == lpst_pkg::OP_QUERY) begin
							state_q <= ST_QUERY;
						end else if (count_q == lpst_pkg::count_t'(lpst_pkg::TABLE_SLOTS)) begin
							state_q <= ST_DROP;
						end else begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_QUERY: begin
					if (out_free) begin
						read_value_q <= used_rd ? {1'b0, val_rd} : '1;
						dropped_q    <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_PROBE: begin
					// a free slot always exists here since the table is not full
					if (used_rd) begin
						pos_q <= nxt_pos;
					end else if (out_free) begin
						count_q      <= count_q + 1'b1;
						read_value_q <= '0;
						dropped_q    <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_DROP: begin
					if (out_free) begin
						read_value_q <= '0;
						dropped_q    <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/lpst_checker.sv
// Port-level checks for the linear probe slot table, bound to the top level.
module lpst_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             op,
	input lpst_pkg::value_t value,
	input logic             out_valid,
	input logic             out_stall,
	input lpst_pkg::read_t  read_value,
	input logic             insert_dropped
);

	// one item in flight: an input transfer closes the input side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) &&
			$stable(insert_dropped))
		else $error("stalled result changed");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && insert_dropped |-> read_value == '0)
		else $error("dropped insert with nonzero read value");

	// stored values are non-negative, so a negative read is only the empty mark
	a_empty_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value[lpst_pkg::READ_W-1] |-> read_value == '1 && !insert_dropped)
		else $error("negative read value other than empty mark");

	// a result never appears with no item in flight
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an accepted item");

endmodule

bind linear_probe_slot_table_top lpst_checker u_lpst_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for the linear probe slot table: queued stimulus, clocked driver/monitor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lpst_pkg::*;

	localparam int IDLE_PCT   = 17;
	localparam int HOLD_LEN   = 300;
	localparam int STALL_AT   = 120;
	localparam int WDOG_LIMIT = 8000;
	localparam int DRAIN_WAIT = 20;

	typedef struct {
		logic   op;
		value_t value;
		bit     wait_drain;	// sender holds this one until all answers are back
	} request_t;

	typedef struct {
		read_t read_value;
		logic  insert_dropped;
	} answer_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	logic   op;
	value_t value;
	logic   out_valid;
	logic   out_stall;
	read_t  read_value;
	logic   insert_dropped;

	request_t requests_to_send[$];
	answer_t  pending_answers[$];
	value_t   placed_values[$];

	// mirror of the table
	value_t slot_data[TABLE_SLOTS];
	bit     slot_live[TABLE_SLOTS];
	int     live_count;

	int n_insert, n_dropped, n_query, n_empty_read;
	int errors;
	int in_count, out_count;
	int idle_cycles;
	int hold_left;
	bit hold_done;
	bit in_xfer, out_xfer;
	bit quiet;
	int ins_queued;

	linear_probe_slot_table_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_value    (read_value),
		.insert_dropped(insert_dropped)
	);

	always #4 clk = ~clk;

	// Insert places at the first free slot from home, wrapping; query reads the home slot.
	function automatic answer_t lookup_or_place(logic op_i, value_t v);
		answer_t a;
		slot_t   pos;
		pos = v[SLOT_W-1:0];
		a.read_value = '0;
		a.insert_dropped = 1'b0;
		if (op_i == OP_QUERY) begin
			n_query++;
			if (slot_live[pos]) begin
				a.read_value = read_t'(slot_data[pos]);
			end else begin
				a.read_value = '1;
				n_empty_read++;
			end
		end else begin
			n_insert++;
			if (live_count >= TABLE_SLOTS) begin
				a.insert_dropped = 1'b1;
				n_dropped++;
			end else begin
				// slot count is a power of two, so pos wraps on its own
				while (slot_live[pos])
					pos = pos + 1'b1;
				slot_live[pos] = 1'b1;
				slot_data[pos] = v;
				live_count++;
			end
		end
		return a;
	endfunction

	function automatic value_t rand_value();
		return value_t'({$urandom, $urandom});
	endfunction

	task automatic push_request(logic op_i, value_t v, bit drain);
		request_t r;
		r.op = op_i;
		r.value = v;
		r.wait_drain = drain;
		requests_to_send.push_back(r);
		if (op_i == OP_INSERT) begin
			ins_queued++;
			placed_values.push_back(v);
		end
	endtask

	// Random insert or query; inserts partly clustered around the ring seam.
	task automatic push_random(int insert_pct, bit drain);
		value_t v;
		v = rand_value();
		if ($urandom_range(99) < insert_pct) begin
			if ($urandom_range(99) < 30)
				v[SLOT_W-1:0] = slot_t'(TABLE_SLOTS - 9 + $urandom_range(17));
			push_request(OP_INSERT, v, drain);
		end else begin
			if (placed_values.size() != 0 && $urandom_range(1) == 1)
				v[SLOT_W-1:0] =
					placed_values[$urandom_range(placed_values.size() - 1)][SLOT_W-1:0];
			push_request(OP_QUERY, v, drain);
		end
	endtask

	// stimulus and end of run
	initial begin
		value_t max_v;
		value_t v;
		in_valid = 1'b0;
		op = OP_INSERT;
		value = '0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		max_v = '1;

		// directed: empty reads, extremes, duplicates, wrap past the top slot
		push_request(OP_QUERY, '0, 1'b0);
		push_request(OP_QUERY, max_v, 1'b0);
		push_request(OP_INSERT, '0, 1'b0);
		push_request(OP_INSERT, max_v, 1'b0);
		push_request(OP_INSERT, max_v, 1'b0);
		push_request(OP_INSERT, value_t'(TABLE_SLOTS - 1), 1'b0);
		push_request(OP_QUERY, '0, 1'b0);
		push_request(OP_QUERY, value_t'(TABLE_SLOTS - 1), 1'b0);
		push_request(OP_QUERY, value_t'(1), 1'b0);
		push_request(OP_QUERY, value_t'(2), 1'b0);
		push_request(OP_QUERY, value_t'(3), 1'b0);
		v = max_v;
		v[SLOT_W-1:0] = slot_t'(5);
		push_request(OP_INSERT, v, 1'b0);
		push_request(OP_QUERY, value_t'(5), 1'b0);
		push_request(OP_INSERT, value_t'({32{2'b01}}), 1'b0);
		push_request(OP_INSERT, value_t'({32{2'b10}}), 1'b0);
		push_request(OP_QUERY, value_t'({32{2'b01}}), 1'b0);
		push_request(OP_QUERY, value_t'({32{2'b10}}), 1'b0);
		push_request(OP_INSERT, value_t'(TABLE_SLOTS - 2), 1'b0);
		push_request(OP_QUERY, value_t'(TABLE_SLOTS - 2), 1'b0);
		push_request(OP_QUERY, max_v - 1'b1, 1'b0);

		// mixed traffic on a partly filled table
		for (int i = 0; i < 400; i++)
			push_random(60, i == 0);
		// insert-heavy until the table is full and inserts start dropping
		push_random(90, 1'b1);
		while (ins_queued < TABLE_SLOTS + 40)
			push_random(90, 1'b0);
		// full table: every query hits, every insert drops
		for (int i = 0; i < 60; i++)
			push_random(50, i == 0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_to_send.size() != 0 || in_valid || pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d inserts (%0d dropped on a full table) and %0d queries",
			n_insert, n_dropped, n_query);
		$display("%0d queries found an empty slot; %0d of %0d slots filled",
			n_empty_read, live_count, TABLE_SLOTS);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	always @(negedge clk) begin
		quiet <= (in_count >= 500 && in_count < 700);
	end

	// input driver
	always @(negedge clk) begin : drive_in
		request_t nxt;
		if (arst_n && (!in_valid || in_xfer)) begin
			if (requests_to_send.size() != 0
				&& !(requests_to_send[0].wait_drain && pending_answers.size() != 0)
				&& (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = requests_to_send.pop_front();
				in_valid <= 1'b1;
				op       <= nxt.op;
				value    <= nxt.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output back-pressure, with one long hold so the block backs up
	always @(negedge clk) begin
		if (!hold_done && in_count >= STALL_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin : watch
		answer_t want;
		in_xfer  = arst_n && in_valid && !in_stall;
		out_xfer = arst_n && out_valid && !out_stall;
		if (out_xfer) begin
			out_count++;
			if (pending_answers.size() == 0) begin
				$error("result with nothing outstanding: read_value %h insert_dropped %b",
					read_value, insert_dropped);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value, read_value);
					errors++;
				end
				if (insert_dropped !== want.insert_dropped) begin
					$error("insert_dropped: expected %b, got %b",
						want.insert_dropped, insert_dropped);
					errors++;
				end
			end
		end
		if (in_xfer) begin
			in_count++;
			pending_answers.push_back(lookup_or_place(op, value));
		end
		if (in_xfer || out_xfer)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no transfer in %0d cycles", WDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
